// ----- rtl/rgpl_pkg.sv -----
// ----------------------------------------------------------------------------
// rgpl_pkg
// Shared types and constants of the rectilinear grid point labeler.
// ----------------------------------------------------------------------------
package rgpl_pkg;

    localparam int MaxCoords  = 64;
    localparam int CoordBits  = $clog2(MaxCoords);
    localparam int CountBits  = 7;
    localparam int LabelDepth = 262144;
    localparam int LabelBits  = $clog2(LabelDepth);
    localparam int IndexBits  = 18;
    localparam int InBits     = 200;
    localparam int OutBits    = 104;
    localparam int CfgIdxBits = 3;

    typedef enum logic [2:0] {
        OP_LOAD_X     = 3'd0,
        OP_LOAD_Y     = 3'd1,
        OP_LOAD_Z     = 3'd2,
        OP_LOAD_LABEL = 3'd3,
        OP_LOCATE     = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_POINT_MODE    = 3'd0,
        CFG_COUNT_X       = 3'd1,
        CFG_COUNT_Y       = 3'd2,
        CFG_COUNT_Z       = 3'd3,
        CFG_LOCAL_PROCESS = 3'd4,
        CFG_MULTI_PROCESS = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]           opcode;
        logic [IndexBits-1:0] table_index;
        logic [31:0]          load_value;
        logic [31:0]          point_x;
        logic [31:0]          point_y;
        logic [31:0]          point_z;
        logic [30:0]          seed_index;
        logic                 to_local;
        logic [14:0]          dest_process;
    } t_cmd;

endpackage

// ----- rtl/rgpl_front.sv -----
// ----------------------------------------------------------------------------
// rgpl_front
// Accepts input words, decodes them, folds the particle id, resolves routing
// and drops unknown opcodes before the command queue.
// ----------------------------------------------------------------------------
module rgpl_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rgpl_pkg::InBits-1:0] i_data,
    input  logic [14:0]                i_local_process,
    input  logic                       i_multi_process,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rgpl_pkg::t_cmd             o_cmd
);
    logic           r_valid;
    rgpl_pkg::t_cmd r_cmd;
    rgpl_pkg::t_cmd n_cmd;
    logic [31:0]    w_pid;
    logic [14:0]    w_origin;
    logic           w_known;

    assign o_ready  = !r_valid || i_ready;
    assign w_pid    = i_data[180:149];
    assign w_origin = i_data[195:181];
    assign w_known  = i_data[2:0] <= rgpl_pkg::OP_LOCATE;

    always_comb begin
        n_cmd.opcode      = i_data[2:0];
        n_cmd.table_index = i_data[20:3];
        n_cmd.load_value  = i_data[52:21];
        n_cmd.point_x     = i_data[84:53];
        n_cmd.point_y     = i_data[116:85];
        n_cmd.point_z     = i_data[148:117];
        n_cmd.seed_index  = w_pid[31] ? ~w_pid[30:0] : w_pid[30:0];
        if (!i_multi_process || w_origin == i_local_process) begin
            n_cmd.to_local     = 1'b1;
            n_cmd.dest_process = '0;
        end else begin
            n_cmd.to_local     = 1'b0;
            n_cmd.dest_process = w_origin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && w_known;
        end
        if (o_ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
endmodule

// ----- rtl/rgpl_fifo.sv -----
// ----------------------------------------------------------------------------
// rgpl_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module rgpl_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rgpl_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output rgpl_pkg::t_cmd o_cmd
);
    rgpl_pkg::t_cmd r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wr] <= i_cmd;
    end
endmodule

// ----- rtl/rgpl_back.sv -----
// ----------------------------------------------------------------------------
// rgpl_back
// Executes commands: table and label loads, and the per-axis scan, the
// linearization and the label read of a locate.
// ----------------------------------------------------------------------------
module rgpl_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  rgpl_pkg::t_cmd                i_cmd,
    input  logic                          i_point_mode,
    input  logic [rgpl_pkg::CountBits-1:0] i_count_x,
    input  logic [rgpl_pkg::CountBits-1:0] i_count_y,
    input  logic [rgpl_pkg::CountBits-1:0] i_count_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rgpl_pkg::OutBits-1:0]  o_data
);
    localparam int CB = rgpl_pkg::CoordBits;
    localparam int NB = rgpl_pkg::CountBits;
    localparam int LB = rgpl_pkg::LabelBits;
    localparam int IndexBits = rgpl_pkg::IndexBits;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MUL1, S_MUL2, S_READ, S_OUT
    } t_state;

    logic [31:0] r_xt [rgpl_pkg::MaxCoords];
    logic [31:0] r_yt [rgpl_pkg::MaxCoords];
    logic [31:0] r_zt [rgpl_pkg::MaxCoords];
    logic [31:0] r_label [rgpl_pkg::LabelDepth];

    t_state         r_state;
    rgpl_pkg::t_cmd r_cmd;
    logic [CB-1:0]  r_i;
    logic [NB-1:0]  r_n;
    logic [NB-1:0]  r_nx;
    logic [NB-1:0]  r_ny;
    logic [NB-1:0]  r_nz;
    logic [31:0]    r_cx;
    logic [31:0]    r_cy;
    logic [31:0]    r_cz;
    logic [CB-1:0]  r_px;
    logic [CB-1:0]  r_py;
    logic [CB-1:0]  r_pz;
    logic [32:0]    r_bx;
    logic [32:0]    r_by;
    logic [32:0]    r_bz;
    logic [2:0]     r_found;
    logic [NB-1:0]  r_ex;
    logic [NB-1:0]  r_ey;
    logic [2*NB-1:0] r_exy;
    logic [LB-1:0]  r_part;
    logic [LB-1:0]  r_idx;
    logic [31:0]    r_lw;
    logic [31:0]    r_tx;
    logic [31:0]    r_ty;
    logic [31:0]    r_tz;
    logic [31:0]    r_ux;
    logic [31:0]    r_uy;
    logic [31:0]    r_uz;

    logic [32:0] w_dx;
    logic [32:0] w_dy;
    logic [32:0] w_dz;
    logic [NB-1:0] w_cnt_x;
    logic [NB-1:0] w_cnt_y;
    logic [NB-1:0] w_cnt_z;
    logic [NB-1:0] w_ip1;
    logic [3*NB-1:0] w_full;

    function automatic logic [NB-1:0] clamp(input logic [NB-1:0] c);
        if (c == '0) return NB'(1);
        if (c > NB'(rgpl_pkg::MaxCoords)) return NB'(rgpl_pkg::MaxCoords);
        return c;
    endfunction

    function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    function automatic logic inside_cell(input logic [31:0] p, input logic [31:0] lo,
                                         input logic [31:0] hi);
        return $signed(p) >= $signed(lo) && $signed(p) <= $signed(hi);
    endfunction

    assign w_cnt_x = clamp(i_count_x);
    assign w_cnt_y = clamp(i_count_y);
    assign w_cnt_z = clamp(i_count_z);
    assign w_dx    = absdiff(r_tx, r_cmd.point_x);
    assign w_dy    = absdiff(r_ty, r_cmd.point_y);
    assign w_dz    = absdiff(r_tz, r_cmd.point_z);
    assign w_ip1   = NB'(r_i) + NB'(1);
    assign w_full  = (3*NB)'(r_pz) * (3*NB)'(r_exy);
    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_state == S_OUT;
    assign o_data  = {7'd0, r_cmd.dest_process, r_cmd.to_local, r_cmd.seed_index,
                      r_idx, r_lw};

    always_ff @(posedge i_clk) begin
        r_tx <= r_xt[r_i];
        r_ty <= r_yt[r_i];
        r_tz <= r_zt[r_i];
        r_ux <= r_xt[CB'(w_ip1)];
        r_uy <= r_yt[CB'(w_ip1)];
        r_uz <= r_zt[CB'(w_ip1)];
        r_lw <= r_label[r_idx];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.opcode)
                            rgpl_pkg::OP_LOAD_X: begin
                                if (i_cmd.table_index < IndexBits'(rgpl_pkg::MaxCoords))
                                    r_xt[CB'(i_cmd.table_index)] <= i_cmd.load_value;
                            end
                            rgpl_pkg::OP_LOAD_Y: begin
                                if (i_cmd.table_index < IndexBits'(rgpl_pkg::MaxCoords))
                                    r_yt[CB'(i_cmd.table_index)] <= i_cmd.load_value;
                            end
                            rgpl_pkg::OP_LOAD_Z: begin
                                if (i_cmd.table_index < IndexBits'(rgpl_pkg::MaxCoords))
                                    r_zt[CB'(i_cmd.table_index)] <= i_cmd.load_value;
                            end
                            rgpl_pkg::OP_LOAD_LABEL: begin
                                r_label[LB'(i_cmd.table_index)] <= i_cmd.load_value;
                            end
                            rgpl_pkg::OP_LOCATE: begin
                                r_i     <= '0;
                                r_n     <= '0;
                                r_nx    <= w_cnt_x;
                                r_ny    <= w_cnt_y;
                                r_nz    <= w_cnt_z;
                                r_px    <= '0;
                                r_py    <= '0;
                                r_pz    <= '0;
                                r_bx    <= '1;
                                r_by    <= '1;
                                r_bz    <= '1;
                                r_found <= '0;
                                r_ex    <= i_point_mode ? w_cnt_x : w_cnt_x - NB'(1);
                                r_ey    <= i_point_mode ? w_cnt_y : w_cnt_y - NB'(1);
                                r_state <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Table reads are registered: r_n trails the read address by one.
                    r_i <= CB'(w_ip1);
                    if (r_i != '0 || r_n != '0) begin
                        if (i_point_mode) begin
                            if (r_n < r_nx && w_dx < r_bx) begin
                                r_bx <= w_dx; r_px <= CB'(r_n);
                            end
                            if (r_n < r_ny && w_dy < r_by) begin
                                r_by <= w_dy; r_py <= CB'(r_n);
                            end
                            if (r_n < r_nz && w_dz < r_bz) begin
                                r_bz <= w_dz; r_pz <= CB'(r_n);
                            end
                        end else begin
                            if (!r_found[0] && r_n + NB'(1) < r_nx &&
                                inside_cell(r_cmd.point_x, r_tx, r_ux)) begin
                                r_found[0] <= 1'b1; r_px <= CB'(r_n);
                            end
                            if (!r_found[1] && r_n + NB'(1) < r_ny &&
                                inside_cell(r_cmd.point_y, r_ty, r_uy)) begin
                                r_found[1] <= 1'b1; r_py <= CB'(r_n);
                            end
                            if (!r_found[2] && r_n + NB'(1) < r_nz &&
                                inside_cell(r_cmd.point_z, r_tz, r_uz)) begin
                                r_found[2] <= 1'b1; r_pz <= CB'(r_n);
                            end
                        end
                        r_n <= r_n + NB'(1);
                        if (r_n == NB'(rgpl_pkg::MaxCoords - 1)) r_state <= S_MUL1;
                    end else begin
                        r_n <= '0;
                    end
                end
                S_MUL1: begin
                    r_exy  <= (2*NB)'(r_ex) * (2*NB)'(r_ey);
                    r_part <= LB'((2*NB)'(r_py) * (2*NB)'(r_ex) + (2*NB)'(r_px));
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_idx   <= LB'(w_full) + r_part;
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_OUT;
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/rectilinear_grid_point_labeler_unit.sv -----
// A locate word is resolved by the 64-step coordinate scan run on all three
// axes at once. Load words are executed by the back end while it is idle; a
// two-word queue decouples it. Throughput: one load per cycle while the back
// end is idle; a new locate is accepted only after the previous result is taken.
// Reset: i_rst_n is synchronous and active low; tables are undefined until loaded.
// ----------------------------------------------------------------------------
// rectilinear_grid_point_labeler_unit
// Labels particle positions against a rectilinear grid and routes the label.
// ----------------------------------------------------------------------------
module rectilinear_grid_point_labeler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode, table_index, load_value, point_x, point_y, point_z,
    // particle_id, origin_process
    input  logic [rgpl_pkg::InBits-1:0]     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // label_word, grid_index, seed_index, to_local, dest_process
    output logic [rgpl_pkg::OutBits-1:0]    m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [rgpl_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [14:0]                     i_cfg_data
);
    logic           r_point_mode;
    logic [6:0]     r_count_x;
    logic [6:0]     r_count_y;
    logic [6:0]     r_count_z;
    logic [14:0]    r_local_process;
    logic           r_multi_process;
    logic           w_f_valid;
    logic           w_f_ready;
    rgpl_pkg::t_cmd w_f_cmd;
    logic           w_q_valid;
    logic           w_q_ready;
    rgpl_pkg::t_cmd w_q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_mode    <= 1'b0;
            r_count_x       <= 7'd1;
            r_count_y       <= 7'd1;
            r_count_z       <= 7'd1;
            r_local_process <= '0;
            r_multi_process <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rgpl_pkg::CFG_POINT_MODE:    r_point_mode    <= i_cfg_data[0];
                rgpl_pkg::CFG_COUNT_X:       r_count_x       <= i_cfg_data[6:0];
                rgpl_pkg::CFG_COUNT_Y:       r_count_y       <= i_cfg_data[6:0];
                rgpl_pkg::CFG_COUNT_Z:       r_count_z       <= i_cfg_data[6:0];
                rgpl_pkg::CFG_LOCAL_PROCESS: r_local_process <= i_cfg_data;
                rgpl_pkg::CFG_MULTI_PROCESS: r_multi_process <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rgpl_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .i_local_process(r_local_process), .i_multi_process(r_multi_process),
        .o_valid(w_f_valid), .i_ready(w_f_ready), .o_cmd(w_f_cmd)
    );

    rgpl_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(w_f_valid), .o_ready(w_f_ready), .i_cmd(w_f_cmd),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_cmd(w_q_cmd)
    );

    rgpl_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_cmd(w_q_cmd),
        .i_point_mode(r_point_mode), .i_count_x(r_count_x),
        .i_count_y(r_count_y), .i_count_z(r_count_z),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );

    a_local_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[81] |-> m_axis_tdata[96:82] == '0)
        else $error("local result carries a destination");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_single_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_multi_process |-> m_axis_tdata[81])
        else $error("single process result routed remote");
endmodule
